>>> design/pairwise_particle_force_step_macros.svh
// Assertion helpers for the force step checker.
`ifndef PAIRWISE_PARTICLE_FORCE_STEP_MACROS_SVH
`define PAIRWISE_PARTICLE_FORCE_STEP_MACROS_SVH

// Checked outside reset.
`define PFS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pfs assertion failed");

// Checked during reset as well.
`define PFS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pfs reset assertion failed");

`endif

>>> design/pfs_pkg.sv
package pfs_pkg;

  localparam int POS_W   = 24;
  localparam int F       = 8;
  localparam int DT_W    = 16;
  localparam int GAIN_W  = 16;
  localparam int MF_W    = 10;
  localparam int CD_W    = 8;
  localparam int COLOR_W = 3;
  localparam int IDX_W   = 6;

  localparam int DIFF_W  = POS_W + 1;
  localparam int D2_W    = 2 * DIFF_W;
  localparam int ROOT_W  = DIFF_W;
  localparam int NUM_W   = 72;
  localparam int LIM_W   = MF_W + F;
  localparam int CT_W    = CD_W + F;
  localparam int TOT_W   = LIM_W + 3;
  localparam int MAG_W   = DIFF_W + TOT_W;
  localparam int KM_W    = GAIN_W + 14;
  localparam int K_W     = KM_W + DT_W;
  localparam int T_CAP   = 60;
  localparam int SHIFT   = 3 * F - 16;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_STEP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  localparam logic [1:0] REG_FORCE_CLAMP  = 2'd0;
  localparam logic [1:0] REG_ATTRACT_GAIN = 2'd1;
  localparam logic [1:0] REG_REPEL_GAIN   = 2'd2;
  localparam logic [1:0] REG_CONTACT_DIST = 2'd3;

  localparam logic [COLOR_W-1:0] COLOR_NEW = 3'd7;
  localparam logic [COLOR_W-1:0] COLOR_CAP = 3'd6;
  localparam logic [COLOR_W-1:0] COLOR_ZERO = 3'd0;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;
  localparam logic [13:0] FORCE_SCALE = 14'd10000;
  localparam logic [15:0] OFS_SCALE = 16'(100 << F);

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   x;
  } atom_t;

endpackage

>>> design/pfs_store.sv
module pfs_store import pfs_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  atom_t         wdata,
  input  logic [AW-1:0] raddr,
  output atom_t         rdata
);

  atom_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pfs_sqrt.sv
module pfs_sqrt import pfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [D2_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [D2_W-1:0]   rad;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] rem_nx;
  logic              ge;

  assign rem_sh = {rem, rad[D2_W-1:D2_W-2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;
  assign rem_nx = ge ? rem_sh - trial : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= {rad[D2_W-3:0], 2'b00};
        rem  <= rem_nx[ROOT_W:0];
        root <= {root[ROOT_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/pfs_div.sv
module pfs_div import pfs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [D2_W-1:0]  den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] nsh;
  logic [D2_W-1:0]  den_r;
  logic [D2_W-1:0]  rem;
  logic [D2_W:0]    rem_sh;
  logic [D2_W:0]    rem_nx;
  logic             ge;

  assign rem_sh = {rem, nsh[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign rem_nx = ge ? rem_sh - {1'b0, den_r} : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(NUM_W);
        nsh   <= num;
        den_r <= den;
        rem   <= '0;
        quo   <= '0;
      end else if (busy) begin
        nsh <= {nsh[NUM_W-2:0], 1'b0};
        rem <= rem_nx[D2_W-1:0];
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/pairwise_particle_force_step.sv
// Pairwise particle force step. Atoms are appended (tuser 0) or the store is
// cleared (tuser 2) by single transactions. A step transaction (tuser 1)
// walks all ordered pairs of the N stored atoms, updating positions in place
// in the atom memory, then streams N result transactions, the last one with
// tlast. The time per pair is set mostly by the shared bit-serial divider
// (five quotients per pair) plus a bit-serial square root. No input is taken
// while a step or its results are in progress. The config channel is always
// ready and may be written only while the block is idle.
module pairwise_particle_force_step import pfs_pkg::*; #(
  parameter int MAX_ATOMS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // x_in[23:0], y_in[47:24], delta_time[63:48]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // atom_index[5:0], x_out[29:6], y_out[53:30],
                                 // color_index[56:54], zero[63:57]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CNT_W = $clog2(MAX_ATOMS + 1);
  localparam int SHL   = (SHIFT > 0) ? SHIFT : 0;
  localparam int SHR   = (SHIFT < 0) ? -SHIFT : 0;

  typedef enum logic [4:0] {
    ST_IDLE, ST_KA, ST_KB, ST_KC, ST_KD, ST_NEXT, ST_RD_CUR, ST_RD_PTR, ST_DIFF,
    ST_OFS_X, ST_OFS_Y, ST_SQ_X, ST_SQ_Y, ST_SUM, ST_SQRT, ST_DIV_ATT, ST_DIV_T,
    ST_DIV_REP, ST_TOTAL, ST_MUL_X, ST_DIV_X, ST_MUL_Y, ST_DIV_Y, ST_WRITE,
    ST_ADV, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
  } state_t;

  state_t state;

  logic [MF_W-1:0]   force_clamp;
  logic [GAIN_W-1:0] attract_gain;
  logic [GAIN_W-1:0] repel_gain;
  logic [CD_W-1:0]   contact_distance;

  logic [CNT_W-1:0]  count;
  logic [AW-1:0]     cur;
  logic [AW-1:0]     ptr;
  logic [DT_W-1:0]   dt;
  logic [KM_W-1:0]   ka_mid;
  logic [KM_W-1:0]   kr_mid;
  logic [K_W-1:0]    ka;
  logic [K_W-1:0]    kr;
  logic [POS_W-1:0]  cx;
  logic [POS_W-1:0]  cy;
  logic [POS_W-1:0]  px;
  logic [POS_W-1:0]  py;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [D2_W-1:0]   sqx;
  logic [D2_W-1:0]   sqy;
  logic [D2_W-1:0]   d2;
  logic [ROOT_W-1:0] d;
  logic [LIM_W-1:0]  att;
  logic [LIM_W-1:0]  rep;
  logic signed [TOT_W-1:0] total;
  logic              neg;
  logic [POS_W-1:0]  nx;
  logic [POS_W-1:0]  ny;
  logic [COLOR_W-1:0] color_new;
  logic [15:0]       lfsr;

  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [D2_W-1:0]   div_den;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic              sqrt_start;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  atom_t             mem_wdata;
  logic [AW-1:0]     mem_raddr;
  atom_t             mem_rdata;

  logic              s_fire;
  logic              append_fire;
  logic signed [DIFF_W-1:0] dx_c;
  logic signed [DIFF_W-1:0] dy_c;
  logic [15:0]       lfsr_nx;
  logic [31:0]       ofs_prod;
  logic [DIFF_W-1:0] ofs;
  logic signed [DIFF_W-1:0] sq_op;
  logic signed [D2_W-1:0]   sq_c;
  logic [D2_W-1:0]   sum_c;
  logic [LIM_W-1:0]  lim;
  logic [NUM_W-1:0]  ka_num;
  logic [NUM_W-1:0]  kr_num;
  logic [LIM_W-1:0]  quo_lim;
  logic [T_CAP:0]    t_c;
  logic [NUM_W+2*F:0] t_sh;
  logic [CT_W-1:0]   contact;
  logic [CT_W-1:0]   push;
  logic signed [TOT_W-1:0] total_c;
  logic signed [DIFF_W-1:0] mul_op;
  logic signed [MAG_W-1:0]  prod_c;
  logic [MAG_W-1:0]  mag_c;
  logic [POS_W-1:0]  moved_c;
  logic [COLOR_W-1:0] color_c;
  logic              adv_ptr_end;
  logic              adv_cur_end;

  function automatic logic [POS_W-1:0] apply_move(
    input logic [POS_W-1:0] pos,
    input logic             dir_neg,
    input logic [MAG_W-1:0] q
  );
    logic signed [MAG_W+1:0] step;
    logic signed [MAG_W+1:0] s;
    logic [POS_W-1:0]        r;
    step = $signed({2'b00, q});
    s = $signed({{(MAG_W+2-POS_W){pos[POS_W-1]}}, pos}) + (dir_neg ? -step : step);
    if (!s[MAG_W+1] && (s[MAG_W:POS_W-1] != '0)) begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end else if (s[MAG_W+1] && (s[MAG_W:POS_W-1] != '1)) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

  assign s_tready    = (state == ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign s_fire      = s_tvalid && s_tready;
  assign append_fire = s_fire && (s_tuser == KIND_APPEND) && (count < CNT_W'(MAX_ATOMS));

  assign dx_c = $signed({mem_rdata.x[POS_W-1], mem_rdata.x}) - $signed({cx[POS_W-1], cx});
  assign dy_c = $signed({mem_rdata.y[POS_W-1], mem_rdata.y}) - $signed({cy[POS_W-1], cy});

  assign lfsr_nx  = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_MASK : 16'h0000);
  assign ofs_prod = lfsr_nx * OFS_SCALE;
  assign ofs      = DIFF_W'(ofs_prod[31:16]);

  assign sq_op = (state == ST_SQ_X) ? dx : dy;
  assign sq_c  = sq_op * sq_op;
  assign sum_c = sqx + sqy;

  assign lim     = {force_clamp, {F{1'b0}}};
  assign ka_num  = (NUM_W'(ka) >> SHR) << SHL;
  assign kr_num  = (NUM_W'(kr) >> SHR) << SHL;
  assign quo_lim = (div_quo >= NUM_W'(lim)) ? lim : div_quo[LIM_W-1:0];
  assign t_c     = (div_quo[NUM_W-1:T_CAP] != '0) ? {1'b1, {T_CAP{1'b0}}} : div_quo[T_CAP:0];
  assign t_sh    = {{(NUM_W-T_CAP){1'b0}}, t_c, {(2*F){1'b0}}};

  assign contact = {contact_distance, {F{1'b0}}};
  assign push    = (d < ROOT_W'(contact)) ? contact - d[CT_W-1:0] : '0;
  assign total_c = $signed({{(TOT_W-LIM_W){1'b0}}, rep}) - $signed({{(TOT_W-LIM_W){1'b0}}, att})
                 + $signed({{(TOT_W-CT_W){1'b0}}, push});

  assign mul_op  = (state == ST_MUL_X) ? dx : dy;
  assign prod_c  = mul_op * total;
  assign mag_c   = prod_c[MAG_W-1] ? MAG_W'(-prod_c) : MAG_W'(prod_c);
  assign moved_c = apply_move((state == ST_DIV_X) ? px : py, neg, div_quo[MAG_W-1:0]);
  assign color_c = (d[ROOT_W-1:F] > (ROOT_W-F)'(COLOR_CAP)) ? COLOR_CAP : d[F+COLOR_W-1:F];

  assign adv_ptr_end = (CNT_W'(ptr) + 1'b1) == count;
  assign adv_cur_end = (CNT_W'(cur) + 1'b1) == count;

  assign mem_we    = (state == ST_WRITE) || append_fire;
  assign mem_waddr = (state == ST_WRITE) ? ptr : count[AW-1:0];
  assign mem_wdata = (state == ST_WRITE) ? atom_t'{color_new, ny, nx}
                                         : atom_t'{COLOR_NEW, s_tdata[47:24], s_tdata[23:0]};
  assign mem_raddr = (state == ST_RD_PTR) ? ptr : cur;

  pfs_store #(.DEPTH(MAX_ATOMS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pfs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (d2),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  pfs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      force_clamp      <= MF_W'(10);
      attract_gain     <= GAIN_W'(3);
      repel_gain       <= GAIN_W'(4000);
      contact_distance <= CD_W'(6);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORCE_CLAMP:  force_clamp      <= cfg_data[MF_W-1:0];
        REG_ATTRACT_GAIN: attract_gain     <= cfg_data[GAIN_W-1:0];
        REG_REPEL_GAIN:   repel_gain       <= cfg_data[GAIN_W-1:0];
        REG_CONTACT_DIST: contact_distance <= cfg_data[CD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      lfsr       <= LFSR_SEED;
      m_tvalid   <= 1'b0;
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
    end else begin
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (append_fire) begin
            count <= count + 1'b1;
          end
          if (s_fire && (s_tuser == KIND_CLEAR)) begin
            count <= '0;
          end
          if (s_fire && (s_tuser == KIND_STEP) && (count != '0)) begin
            dt    <= s_tdata[63:48];
            cur   <= '0;
            ptr   <= '0;
            state <= ST_KA;
          end
        end
        ST_KA: begin
          ka_mid <= attract_gain * FORCE_SCALE;
          state  <= ST_KB;
        end
        ST_KB: begin
          kr_mid <= repel_gain * FORCE_SCALE;
          state  <= ST_KC;
        end
        ST_KC: begin
          ka    <= ka_mid * dt;
          state <= ST_KD;
        end
        ST_KD: begin
          kr    <= kr_mid * dt;
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          state <= (cur == ptr) ? ST_ADV : ST_RD_CUR;
        end
        ST_RD_CUR: begin
          state <= ST_RD_PTR;
        end
        ST_RD_PTR: begin
          cx    <= mem_rdata.x;
          cy    <= mem_rdata.y;
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          px    <= mem_rdata.x;
          py    <= mem_rdata.y;
          dx    <= dx_c;
          dy    <= dy_c;
          state <= ((dx_c == '0) && (dy_c == '0)) ? ST_OFS_X : ST_SQ_X;
        end
        ST_OFS_X: begin
          lfsr  <= lfsr_nx;
          dx    <= $signed(ofs);
          state <= ST_OFS_Y;
        end
        ST_OFS_Y: begin
          lfsr  <= lfsr_nx;
          dy    <= $signed(ofs);
          state <= ST_SQ_X;
        end
        ST_SQ_X: begin
          sqx   <= sq_c;
          state <= ST_SQ_Y;
        end
        ST_SQ_Y: begin
          sqy   <= sq_c;
          state <= ST_SUM;
        end
        ST_SUM: begin
          d2 <= sum_c;
          if (sum_c == '0) begin
            nx        <= px;
            ny        <= py;
            color_new <= COLOR_ZERO;
            state     <= ST_WRITE;
          end else begin
            sqrt_start <= 1'b1;
            state      <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            d         <= sqrt_root;
            div_num   <= ka_num;
            div_den   <= d2;
            div_start <= 1'b1;
            state     <= ST_DIV_ATT;
          end
        end
        ST_DIV_ATT: begin
          if (div_done) begin
            att       <= quo_lim;
            div_num   <= kr_num;
            div_start <= 1'b1;
            state     <= ST_DIV_T;
          end
        end
        ST_DIV_T: begin
          if (div_done) begin
            div_num   <= t_sh[NUM_W-1:0];
            div_start <= 1'b1;
            state     <= ST_DIV_REP;
          end
        end
        ST_DIV_REP: begin
          if (div_done) begin
            rep   <= quo_lim;
            state <= ST_TOTAL;
          end
        end
        ST_TOTAL: begin
          total     <= total_c;
          color_new <= color_c;
          state     <= ST_MUL_X;
        end
        ST_MUL_X, ST_MUL_Y: begin
          neg       <= prod_c[MAG_W-1];
          div_num   <= NUM_W'(mag_c);
          div_den   <= D2_W'(d);
          div_start <= 1'b1;
          state     <= (state == ST_MUL_X) ? ST_DIV_X : ST_DIV_Y;
        end
        ST_DIV_X: begin
          if (div_done) begin
            nx    <= moved_c;
            state <= ST_MUL_Y;
          end
        end
        ST_DIV_Y: begin
          if (div_done) begin
            ny    <= moved_c;
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state <= ST_ADV;
        end
        ST_ADV: begin
          if (adv_ptr_end) begin
            ptr <= '0;
            if (adv_cur_end) begin
              cur   <= '0;
              state <= ST_EMIT_RD;
            end else begin
              cur   <= cur + 1'b1;
              state <= ST_NEXT;
            end
          end else begin
            ptr   <= ptr + 1'b1;
            state <= ST_NEXT;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          m_tdata  <= {7'b0, mem_rdata.color, mem_rdata.y, mem_rdata.x, IDX_W'(cur)};
          m_tlast  <= adv_cur_end;
          m_tvalid <= 1'b1;
          state    <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= ST_IDLE;
            end else begin
              cur   <= cur + 1'b1;
              state <= ST_EMIT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/pfs_checker.sv
`include "pairwise_particle_force_step_macros.svh"

module pfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast
);

  // input side is closed while results are pending
  `PFS_ASSERT(a_no_overlap, !(s_tready && m_tvalid))
  `PFS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tlast}))
  `PFS_ASSERT(a_last_ends, m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
  `PFS_ASSERT_RST(a_rst_quiet, rst |=> !m_tvalid)

endmodule

bind pairwise_particle_force_step pfs_checker u_pfs_checker (.*);

>>> test/pairwise_particle_force_step_checker.sv
`timescale 1ns / 1ps

module pairwise_particle_force_step_checker import pfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam int MAX_ATOMS = 64;
  localparam longint signed POS_HI = 64'sd8388607;
  localparam longint signed POS_LO = -64'sd8388608;
  localparam longint unsigned FORCE_LIMIT = 64'd1 << T_CAP;

  typedef struct {
    logic [IDX_W-1:0]   index;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } atom_report_t;

  atom_report_t report_q[$];

  longint signed       pos_x[MAX_ATOMS];
  longint signed       pos_y[MAX_ATOMS];
  logic [COLOR_W-1:0]  shade[MAX_ATOMS];
  int                  atom_total;
  logic [15:0]         jitter_lfsr;
  longint unsigned     force_clamp, attract_gain, repel_gain, contact_dist;
  int                  mismatch_cnt;

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned scaled_quot(longint unsigned a, int e,
                                                  longint unsigned b,
                                                  longint unsigned lim);
    longint unsigned q, r;
    if (e < 0) begin
      a = a >> (-e);
      e = 0;
    end
    q = a / b;
    r = a % b;
    if (q >= lim) return lim;
    for (int i = 0; i < e; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= b) begin
        r = r - b;
        q = q + 1;
      end
      if (q >= lim) return lim;
    end
    return q;
  endfunction

  function automatic longint signed clamp_pos(longint signed v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  function automatic longint signed move_along(longint signed comp, longint signed total,
                                               longint unsigned d);
    longint signed num;
    longint unsigned mag, q;
    num = comp * total;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = mag / d;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint signed next_jitter();
    logic [15:0] v;
    v = jitter_lfsr >> 1;
    if (jitter_lfsr[0]) v = v ^ LFSR_MASK;
    jitter_lfsr = v;
    return longint'((longint'(v) * (longint'(100) << F)) >> 16);
  endfunction

  task automatic push_pair(int c, int p, longint unsigned dt);
    longint signed dx, dy, total;
    longint unsigned d2, d, lim, att, rep, t, contact, ka, kr, px;
    dx = pos_x[p] - pos_x[c];
    dy = pos_y[p] - pos_y[c];
    if (dx == 0 && dy == 0) begin
      dx = next_jitter();
      dy = next_jitter();
    end
    d2 = dx * dx + dy * dy;
    if (d2 == 0) begin
      shade[p] = COLOR_ZERO;
      return;
    end
    d = root_floor(d2);
    lim = force_clamp << F;
    ka = attract_gain * 10000 * dt;
    kr = repel_gain * 10000 * dt;
    att = scaled_quot(ka, SHIFT, d2, lim);
    t = scaled_quot(kr, SHIFT, d2, FORCE_LIMIT);
    rep = scaled_quot(t, 2 * F, d2, lim);
    total = longint'(rep) - longint'(att);
    contact = contact_dist << F;
    if (d < contact) total = total + longint'(contact - d);
    pos_x[p] = clamp_pos(pos_x[p] + move_along(dx, total, d));
    pos_y[p] = clamp_pos(pos_y[p] + move_along(dy, total, d));
    px = d >> F;
    shade[p] = (px > 6) ? COLOR_CAP : COLOR_W'(px);
  endtask

  task automatic apply_item(logic [1:0] k, logic [63:0] data);
    atom_report_t rpt;
    case (k)
      KIND_APPEND: begin
        if (atom_total < MAX_ATOMS) begin
          pos_x[atom_total] = longint'($signed(data[23:0]));
          pos_y[atom_total] = longint'($signed(data[47:24]));
          shade[atom_total] = COLOR_NEW;
          atom_total++;
        end
      end
      KIND_CLEAR: atom_total = 0;
      KIND_STEP: begin
        for (int c = 0; c < atom_total; c++)
          for (int p = 0; p < atom_total; p++)
            if (c != p) push_pair(c, p, longint'(data[63:48]));
        for (int c = 0; c < atom_total; c++) begin
          rpt.index = IDX_W'(c);
          rpt.x = pos_x[c][POS_W-1:0];
          rpt.y = pos_y[c][POS_W-1:0];
          rpt.color = shade[c];
          rpt.last = (c == atom_total - 1);
          report_q.push_back(rpt);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_report(logic [63:0] data, logic lst);
    atom_report_t want;
    if (report_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t unexpected result transaction: data %h last %b", $realtime, data, lst);
      return;
    end
    want = report_q.pop_front();
    if (data[5:0] !== want.index || data[29:6] !== want.x || data[53:30] !== want.y ||
        data[56:54] !== want.color || lst !== want.last) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("%0t mismatch: expected idx %0d x %h y %h color %0d last %b,",
                 $realtime, want.index, want.x, want.y, want.color, want.last);
        $display("  got idx %0d x %h y %h color %0d last %b",
                 data[5:0], data[29:6], data[53:30], data[56:54], lst);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      report_q.delete();
      atom_total = 0;
      jitter_lfsr = LFSR_SEED;
      force_clamp = 10;
      attract_gain = 3;
      repel_gain = 4000;
      contact_dist = 6;
      mismatch_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FORCE_CLAMP:  force_clamp = cfg_data & 16'h03FF;
          REG_ATTRACT_GAIN: attract_gain = cfg_data;
          REG_REPEL_GAIN:   repel_gain = cfg_data;
          REG_CONTACT_DIST: contact_dist = cfg_data & 16'h00FF;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) check_report(m_tdata, m_tlast);
      if (s_tvalid && s_tready) apply_item(s_tuser, s_tdata);
    end
    pending <= report_q.size();
    errors <= mismatch_cnt;
  end

endmodule

>>> test/pairwise_particle_force_step_test.sv
`timescale 1ns / 1ps

module pairwise_particle_force_step_test import pfs_pkg::*; ();

  localparam int QUIET_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = KIND_APPEND;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_FORCE_CLAMP;
  logic [15:0] cfg_data = '0;
  int          errors, pending;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int quiet = 0;
  int loaded = 0;
  int steps_sent = 0;
  int items_sent = 0;
  int results_seen = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pairwise_particle_force_step dut (.*);

  pairwise_particle_force_step_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_cnt <= 4000;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) results_seen++;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(logic [1:0] k, logic [23:0] x, logic [23:0] y, logic [15:0] dt);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= {dt, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (k == KIND_STEP) steps_sent++;
    if (k == KIND_CLEAR) loaded = 0;
    if (k == KIND_APPEND && loaded < 64) loaded++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_regs(logic [15:0] mf, logic [15:0] ag, logic [15:0] rg, logic [15:0] cd);
    settle();
    write_reg(REG_FORCE_CLAMP, mf);
    write_reg(REG_ATTRACT_GAIN, ag);
    write_reg(REG_REPEL_GAIN, rg);
    write_reg(REG_CONTACT_DIST, cd);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_batch();
    int n, cx, cy, x, y, r;
    logic [23:0] px, py;
    send(KIND_CLEAR, 24'($urandom), 24'($urandom), 16'($urandom));
    n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(2, 7);
    cx = int'($urandom_range(16000000)) - 8000000;
    cy = int'($urandom_range(16000000)) - 8000000;
    px = 24'(cx);
    py = 24'(cy);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(9);
      if (r < 6) begin
        x = cx + int'($urandom_range(12000)) - 6000;
        y = cy + int'($urandom_range(12000)) - 6000;
        px = 24'(x);
        py = 24'(y);
      end else if (r < 8 && i > 0) begin
      end else begin
        px = 24'($urandom);
        py = 24'($urandom);
      end
      send(KIND_APPEND, px, py, 16'($urandom));
      if ($urandom_range(19) == 0) send(KIND_SPARE, 24'($urandom), 24'($urandom), 16'($urandom));
    end
    repeat ($urandom_range(1, 3)) send(KIND_STEP, 24'($urandom), 24'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, extremes, coincident atoms, noise, empty step
    send(KIND_STEP, 24'h0, 24'h0, 16'hFFFF);
    send(KIND_APPEND, 24'h7FFFFF, 24'h800000, 16'h0);
    send(KIND_APPEND, 24'h800000, 24'h7FFFFF, 16'h0);
    send(KIND_STEP, 24'h0, 24'h0, 16'hFFFF);
    send(KIND_CLEAR, 24'h0, 24'h0, 16'h0);
    repeat (3) send(KIND_APPEND, 24'h000000, 24'h000000, 16'h0);
    send(KIND_APPEND, 24'h000300, 24'hFFFD00, 16'h0);
    send(KIND_SPARE, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send(KIND_STEP, 24'h0, 24'h0, 16'h0000);
    send(KIND_STEP, 24'h0, 24'h0, 16'h1234);
    send(KIND_APPEND, 24'h7FFFFF, 24'h7FFFFF, 16'h0);
    send(KIND_STEP, 24'h0, 24'h0, 16'hFFFF);
    // fill the store past capacity; extra appends are dropped
    send(KIND_CLEAR, 24'h0, 24'h0, 16'h0);
    for (int i = 0; i < 66; i++) send(KIND_APPEND, 24'($urandom), 24'($urandom), 16'h0);
    send(KIND_CLEAR, 24'h0, 24'h0, 16'h0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_regs(16'd1, 16'd0, 16'd0, 16'd0);
        1: load_regs(16'h0400, 16'hFFFF, 16'd0, 16'd255);
        2: load_regs(16'd1023, 16'hFFFF, 16'hFFFF, 16'd255);
        3: load_regs(16'($urandom_range(1, 1023)), 16'($urandom), 16'($urandom),
                     16'($urandom_range(255)));
        default: load_regs(16'd10, 16'd3, 16'd4000, 16'd6);
      endcase
      idle_pct  = (ph == 1 || ph == 3) ? 85 : (ph == 4 ? 27 : 0);
      stall_pct = (ph == 2 || ph == 3) ? 85 : (ph == 4 ? 27 : 0);
      if (ph == 0) begin
        // long receiver hold-off while items keep coming
        send(KIND_CLEAR, 24'h0, 24'h0, 16'h0);
        for (int i = 0; i < 3; i++) send(KIND_APPEND, 24'(i * 800), 24'(i * 300), 16'h0);
        hold_seq++;
        send(KIND_STEP, 24'h0, 24'h0, 16'h8000);
        send(KIND_STEP, 24'h0, 24'h0, 16'h4000);
        send(KIND_APPEND, 24'h001000, 24'h001000, 16'h0);
      end
      repeat ((ph == 4) ? 2 : 1) random_batch();
    end

    settle();
    $display("Covered %0d input transactions (%0d steps), %0d atom reports checked,",
             items_sent, steps_sent, results_seen);
    $display("five register settings incl. limits, with sender/receiver idling phases.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/pfs_pkg.sv
design/pfs_store.sv
design/pfs_sqrt.sv
design/pfs_div.sv
design/pairwise_particle_force_step.sv
design/pfs_checker.sv
test/pairwise_particle_force_step_checker.sv
test/pairwise_particle_force_step_test.sv
